@@ rtl/core/pts_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants for the presence-triggered power sequencer.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int TimerWidthDefault = 17;
  localparam int DistWidth         = 13;
  localparam int CountWidth        = 4;
  localparam int DelayWidth        = 17;
  localparam int PhaseWidth        = 3;
  localparam int CfgIdxWidth       = 8;
  localparam int CfgDataWidth      = 17;

  localparam logic [CfgIdxWidth-1:0] CfgTriggerDistance = CfgIdxWidth'(0);
  localparam logic [CfgIdxWidth-1:0] CfgStableCount     = CfgIdxWidth'(1);
  localparam logic [CfgIdxWidth-1:0] CfgShutdownDelay   = CfgIdxWidth'(2);
  localparam logic [CfgIdxWidth-1:0] CfgCooldownTime    = CfgIdxWidth'(3);

  localparam logic [DistWidth-1:0]  TriggerDistanceRst = DistWidth'(50);
  localparam logic [CountWidth-1:0] StableCountRst     = CountWidth'(2);
  localparam logic [DelayWidth-1:0] ShutdownDelayRst   = DelayWidth'(20000);
  localparam logic [DelayWidth-1:0] CooldownTimeRst    = DelayWidth'(5000);

  localparam logic [CountWidth-1:0] NearMax = {CountWidth{1'b1}};

  localparam logic KindTick    = 1'b0;
  localparam logic KindRequest = 1'b1;

  typedef enum logic [PhaseWidth-1:0] {
    PH_IDLE      = 3'd0,
    PH_POWERING  = 3'd1,
    PH_RECORDING = 3'd2,
    PH_SHUTDOWN  = 3'd3,
    PH_COOLDOWN  = 3'd4
  } phase_e;

endpackage
`default_nettype wire

@@ rtl/core/presence_triggered_power_sequencer_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// presence_triggered_power_sequencer_core
// Power sequencer for a companion computer driven by ticks and power requests.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item per transfer:
//   a 1 ms tick (range sample, ready line) or a power request. Every item
//   yields exactly one result on the output channel (out_valid_o /
//   out_stall_i) with the phase and power/mode/signal/owned flags after it.
//   Config writes go through cfg_valid_i / cfg_ready_o; ready is always high.
//   A result passes through the input register, then the sequencer state
//   which doubles as result register. Throughput: one item per cycle while
//   out_stall_i is low, set by the single state update stage.
//   While out_stall_i holds a result, the input register keeps one more item
//   and in_stall_o rises only when both stages are full.
//   Reset clears all state but the input data registers: phase idle, power off,
//   counters zero, config registers at their defaults.
// ----------------------------------------------------------------------------
module presence_triggered_power_sequencer_core #(
  parameter int TIMER_WIDTH = pts_pkg::TimerWidthDefault
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,

  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [pts_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  wire logic [pts_pkg::CfgDataWidth-1:0] cfg_data_i,

  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             kind_i,
  input  wire logic [pts_pkg::DistWidth-1:0]    range_mm_i,
  input  wire logic                             distance_valid_i,
  input  wire logic                             ready_level_i,
  input  wire logic                             turn_on_i,
  input  wire logic                             manual_i,

  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic                                  power_enable_o,
  output logic                                  led_on_o,
  output logic                                  mode_line_o,
  output logic                                  record_signal_o,
  output logic [pts_pkg::PhaseWidth-1:0]        phase_o,
  output logic                                  user_owned_o
);
  import pts_pkg::*;

  localparam int CmpWidth = (TIMER_WIDTH > DelayWidth) ? TIMER_WIDTH : DelayWidth;
  localparam logic [TIMER_WIDTH-1:0] TimerMax = {TIMER_WIDTH{1'b1}};

  // config registers
  logic [DistWidth-1:0]  trigger_distance_q;
  logic [CountWidth-1:0] stable_count_q;
  logic [DelayWidth-1:0] shutdown_delay_q;
  logic [DelayWidth-1:0] cooldown_time_q;

  // input register
  logic                 in_valid_q;
  logic                 kind_q;
  logic [DistWidth-1:0] dist_q;
  logic                 dist_valid_q;
  logic                 ready_q;
  logic                 turn_on_q;
  logic                 manual_q;

  // sequencer state, also the result register
  logic                   out_valid_q;
  phase_e                 phase_q, phase_d;
  logic [CountWidth-1:0]  near_q, near_d;
  logic [TIMER_WIDTH-1:0] elapsed_q, elapsed_d;
  logic                   owned_q, owned_d;
  logic                   power_q, power_d;
  logic                   mode_q, mode_d;
  logic                   signal_q, signal_d;

  logic                   advance;
  logic                   load_in;
  logic                   upd;
  logic [TIMER_WIDTH-1:0] elapsed_inc;
  logic [CountWidth-1:0]  near_inc;
  logic                   shutdown_done;
  logic                   cooldown_done;

  assign advance    = !out_valid_q || !out_stall_i;
  assign load_in    = !in_valid_q || advance;
  assign upd        = in_valid_q && advance;
  assign in_stall_o = !load_in;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trigger_distance_q <= TriggerDistanceRst;
      stable_count_q     <= StableCountRst;
      shutdown_delay_q   <= ShutdownDelayRst;
      cooldown_time_q    <= CooldownTimeRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgTriggerDistance: trigger_distance_q <= cfg_data_i[DistWidth-1:0];
        CfgStableCount:     stable_count_q     <= cfg_data_i[CountWidth-1:0];
        CfgShutdownDelay:   shutdown_delay_q   <= cfg_data_i[DelayWidth-1:0];
        CfgCooldownTime:    cooldown_time_q    <= cfg_data_i[DelayWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (load_in) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in && in_valid_i) begin
      kind_q       <= kind_i;
      dist_q       <= range_mm_i;
      dist_valid_q <= distance_valid_i;
      ready_q      <= ready_level_i;
      turn_on_q    <= turn_on_i;
      manual_q     <= manual_i;
    end
  end

  assign elapsed_inc   = (elapsed_q == TimerMax) ? elapsed_q : elapsed_q + TIMER_WIDTH'(1);
  assign near_inc      = (near_q == NearMax) ? near_q : near_q + CountWidth'(1);
  assign shutdown_done = CmpWidth'(elapsed_inc) > CmpWidth'(shutdown_delay_q);
  assign cooldown_done = CmpWidth'(elapsed_inc) > CmpWidth'(cooldown_time_q);

  always_comb begin
    phase_d   = phase_q;
    near_d    = near_q;
    elapsed_d = elapsed_q;
    owned_d   = owned_q;
    power_d   = power_q;
    mode_d    = mode_q;
    signal_d  = signal_q;
    if (kind_q == KindRequest) begin
      elapsed_d = '0;
      if (turn_on_q) begin
        owned_d = manual_q;
        mode_d  = manual_q;
        power_d = 1'b1;
        phase_d = PH_POWERING;
      end else begin
        phase_d = power_q ? PH_SHUTDOWN : PH_COOLDOWN;
      end
    end else begin
      case (phase_q)
        PH_IDLE: begin
          if (!owned_q && dist_valid_q) begin
            if (dist_q < trigger_distance_q) begin
              if (near_inc >= stable_count_q) begin
                near_d    = '0;
                owned_d   = 1'b0;
                mode_d    = 1'b0;
                power_d   = 1'b1;
                phase_d   = PH_POWERING;
                elapsed_d = '0;
              end else begin
                near_d = near_inc;
              end
            end else begin
              near_d = '0;
            end
          end
        end
        PH_POWERING: begin
          if (ready_q) begin
            signal_d  = 1'b1;
            phase_d   = PH_RECORDING;
            elapsed_d = '0;
          end
        end
        PH_RECORDING: begin
          if (!ready_q) begin
            phase_d   = PH_SHUTDOWN;
            elapsed_d = '0;
          end
        end
        PH_SHUTDOWN: begin
          elapsed_d = elapsed_inc;
          if (shutdown_done) begin
            power_d   = 1'b0;
            owned_d   = 1'b0;
            phase_d   = PH_COOLDOWN;
            elapsed_d = '0;
          end
        end
        PH_COOLDOWN: begin
          elapsed_d = elapsed_inc;
          if (cooldown_done) begin
            phase_d = PH_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= PH_IDLE;
      near_q      <= '0;
      elapsed_q   <= '0;
      owned_q     <= 1'b0;
      power_q     <= 1'b0;
      mode_q      <= 1'b0;
      signal_q    <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (upd) begin
        phase_q   <= phase_d;
        near_q    <= near_d;
        elapsed_q <= elapsed_d;
        owned_q   <= owned_d;
        power_q   <= power_d;
        mode_q    <= mode_d;
        signal_q  <= signal_d;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign power_enable_o  = power_q;
  assign led_on_o        = power_q;
  assign mode_line_o     = mode_q;
  assign record_signal_o = signal_q;
  assign phase_o         = phase_q;
  assign user_owned_o    = owned_q;

  a_owned_needs_power: assert property (@(posedge clk_i) disable iff (!rst_ni)
    owned_q |-> power_q)
    else $error("user owned without power");

  a_signal_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(signal_q))
    else $error("record signal cleared");

  a_active_powered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_POWERING || phase_q == PH_RECORDING) |-> power_q)
    else $error("powering or recording with power off");

  a_state_only_on_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !upd |=> $stable(phase_q) && $stable(elapsed_q) && $stable(power_q))
    else $error("state changed without a transfer");

endmodule
`default_nettype wire
